// ----- rtl/raw_line_adaptive_denoise_core_macros.svh -----
// Assertion macros shared by the denoise RTL.
`ifndef RAW_LINE_ADAPTIVE_DENOISE_CORE_MACROS_SVH
`define RAW_LINE_ADAPTIVE_DENOISE_CORE_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define RLAD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RLAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/rlad_pkg.sv -----
// Shared constants and codes of the raw line denoise block.
`timescale 1ns / 1ps
package rlad_pkg;

  localparam int PIX_W          = 16;
  localparam int SHIFT_W        = 5;
  localparam int MODE_W         = 2;
  localparam int PIXEL_BITS_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_CLAMP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_3TAP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_5TAP  = 2'd2;

  localparam logic [1:0] POS_START = 2'd0;
  localparam logic [1:0] POS_ONE   = 2'd1;
  localparam logic [1:0] POS_FULL  = 2'd2;

endpackage

// ----- rtl/rlad_in_if.sv -----
// Input pixel channel of the raw line denoise block.
`timescale 1ns / 1ps
interface rlad_in_if;
  logic                         valid;
  logic                         ready;
  logic [rlad_pkg::PIX_W-1:0]   pixel_in;
  logic [rlad_pkg::SHIFT_W-1:0] block_shift;
  logic [rlad_pkg::MODE_W-1:0]  noise_mode;
  logic                         last_in;

  modport source (output valid, pixel_in, block_shift, noise_mode, last_in, input ready);
  modport sink   (input valid, pixel_in, block_shift, noise_mode, last_in, output ready);
endinterface

// ----- rtl/rlad_out_if.sv -----
// Result pixel channel of the raw line denoise block.
`timescale 1ns / 1ps
interface rlad_out_if;
  logic                       valid;
  logic                       ready;
  logic [rlad_pkg::PIX_W-1:0] pixel_out;
  logic                       last_out;

  modport source (output valid, pixel_out, last_out, input ready);
  modport sink   (input valid, pixel_out, last_out, output ready);
endinterface

// ----- rtl/raw_line_adaptive_denoise_core.sv -----
// Raw line adaptive denoise: top level with window, flush sequencer and filter.
`timescale 1ns / 1ps
// Usage:
//   in_ch takes one raw pixel per beat with the shift of its 32-pixel block,
//   the noise mode (sampled on the first beat of a line only) and last_in on
//   the final pixel of the line. out_ch gives the filtered pixels in line
//   order, last_out on the final one of the line.
//   Throughput: one input beat per cycle inside a line while the receiver
//   does not stall. The beat carrying last_in is followed by flush cycles in
//   which in_ch.ready is low, since the five-pixel window shifts in copies
//   of the edge pixel one per cycle while the output register can take one:
//   none for a line of a single pixel, one for two pixels, two otherwise.
//   A result is filtered combinationally from the window registers and
//   loaded into the output register; the stream lags the input by two
//   pixels.
//   Reset (rst_n low, synchronous) empties the output register, drops any
//   pending flush and returns to the start of a line.
//   Receiver stall: the output register holds its beat; the window keeps
//   taking pixels while no result is pending in it, then in_ch.ready drops
//   until the held beat is taken.
module raw_line_adaptive_denoise_core #(
  parameter int PIXEL_BITS = rlad_pkg::PIXEL_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  rlad_in_if.sink           in_ch,
  rlad_out_if.source        out_ch
);

  `include "raw_line_adaptive_denoise_core_macros.svh"

  localparam int PB = PIXEL_BITS;
  localparam int PW = rlad_pkg::PIX_W;
  localparam int SW = rlad_pkg::SHIFT_W;
  localparam int MW = rlad_pkg::MODE_W;

  // Pixel window, oldest first; center is entry 2.
  logic [PB-1:0] win_r   [5];
  logic [PB-1:0] win_nxt [5];
  // Shifts of the last three pixels; entry 0 belongs to the center.
  logic [SW-1:0] shift_r   [3];
  logic [SW-1:0] shift_nxt [3];
  logic [1:0]    pos_r, pos_nxt, pos_eff;
  logic [MW-1:0] mode_r, mode_nxt;
  // emit_r: the window holds a result still to be filtered.
  logic          emit_r, emit_nxt;
  logic          emit_last_r, emit_last_nxt;
  // Copies of the edge pixel still to shift in after the pending result.
  logic [1:0]    flush_r, flush_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_pix_r, out_pix_nxt;
  logic          out_last_r, out_last_nxt;

  logic          slot_free, fire_out, in_ready, fire_in;
  logic          last_full_in;
  logic [PB-1:0] pix;
  logic [PB-1:0] filt;

  // Filter datapath signals.
  logic [PB+1:0]        sum3;
  logic [PB+2:0]        sum5;
  logic [PB-1:0]        smooth3, smooth5, limited;
  logic signed [PB:0]   diff, lim_h;
  logic [SW-1:0]        lim_k;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign fire_out  = emit_r && slot_free;
  // Hold input during a flush, or while a pending result cannot move out.
  assign in_ready  = (flush_r == 2'd0) && (!emit_r || slot_free);
  assign fire_in   = in_ch.valid && in_ready;
  assign pix       = in_ch.pixel_in[PB-1:0];
  // A position beyond "full" counts as full.
  assign pos_eff   = (pos_r == rlad_pkg::POS_START || pos_r == rlad_pkg::POS_ONE)
                     ? pos_r : rlad_pkg::POS_FULL;
  // Last pixel of a line taken while the window is full.
  assign last_full_in = fire_in && in_ch.last_in && (pos_eff == rlad_pkg::POS_FULL);

  // Filter the current window. Sums are rounded before the shift.
  always_comb begin
    sum3 = {2'b00, win_r[1]} + {1'b0, win_r[2], 1'b0} + {2'b00, win_r[3]}
           + (PB+2)'(2);
    smooth3 = sum3[PB+1:2];
    sum5 = {3'b000, win_r[0]} + {2'b00, win_r[1], 1'b0} + {2'b00, win_r[2], 1'b0}
           + {2'b00, win_r[3], 1'b0} + {3'b000, win_r[4]} + (PB+3)'(4);
    smooth5 = sum5[PB+2:3];

    // Limit the smoothing step to half of 2^shift of the center block.
    diff    = $signed({1'b0, smooth3}) - $signed({1'b0, win_r[2]});
    lim_k   = shift_r[0] - SW'(1);
    lim_h   = $signed((PB+1)'(1) << lim_k);
    limited = smooth3;
    if (shift_r[0] == '0) begin
      limited = win_r[2];
    end else if (lim_k < SW'(PB)) begin
      if (diff > lim_h) begin
        limited = win_r[2] + lim_h[PB-1:0];
      end else if (diff < -lim_h) begin
        limited = win_r[2] - lim_h[PB-1:0];
      end
    end

    case (mode_r)
      rlad_pkg::MODE_CLAMP: filt = limited;
      rlad_pkg::MODE_3TAP:  filt = smooth3;
      default:              filt = smooth5;
    endcase
  end

  // Window, line position and flush sequencing.
  always_comb begin
    win_nxt       = win_r;
    shift_nxt     = shift_r;
    pos_nxt       = pos_r;
    mode_nxt      = mode_r;
    emit_nxt      = emit_r;
    emit_last_nxt = emit_last_r;
    flush_nxt     = flush_r;

    if (fire_out) begin
      if (flush_r != 2'd0) begin
        // Advance the window with a copy of the edge pixel.
        win_nxt       = '{win_r[1], win_r[2], win_r[3], win_r[4], win_r[4]};
        shift_nxt     = '{shift_r[1], shift_r[2], shift_r[2]};
        emit_nxt      = 1'b1;
        emit_last_nxt = (flush_r == 2'd1);
        flush_nxt     = flush_r - 2'd1;
      end else begin
        emit_nxt      = 1'b0;
        emit_last_nxt = 1'b0;
      end
    end

    if (fire_in) begin
      case (pos_eff)
        rlad_pkg::POS_START: begin
          // Fill the window: repeats the left edge.
          mode_nxt  = in_ch.noise_mode;
          win_nxt   = '{pix, pix, pix, pix, pix};
          shift_nxt = '{in_ch.block_shift, in_ch.block_shift, in_ch.block_shift};
          if (in_ch.last_in) begin
            emit_nxt      = 1'b1;
            emit_last_nxt = 1'b1;
            flush_nxt     = 2'd0;
            pos_nxt       = rlad_pkg::POS_START;
          end else begin
            pos_nxt       = rlad_pkg::POS_ONE;
          end
        end
        rlad_pkg::POS_ONE: begin
          if (in_ch.last_in) begin
            // Push the pixel and its first copy at once.
            win_nxt       = '{win_r[2], win_r[3], win_r[4], pix, pix};
            shift_nxt     = '{shift_r[2], in_ch.block_shift, in_ch.block_shift};
            emit_nxt      = 1'b1;
            emit_last_nxt = 1'b0;
            flush_nxt     = 2'd1;
            pos_nxt       = rlad_pkg::POS_START;
          end else begin
            win_nxt       = '{win_r[1], win_r[2], win_r[3], win_r[4], pix};
            shift_nxt     = '{shift_r[1], shift_r[2], in_ch.block_shift};
            pos_nxt       = rlad_pkg::POS_FULL;
          end
        end
        default: begin
          win_nxt       = '{win_r[1], win_r[2], win_r[3], win_r[4], pix};
          shift_nxt     = '{shift_r[1], shift_r[2], in_ch.block_shift};
          emit_nxt      = 1'b1;
          emit_last_nxt = 1'b0;
          flush_nxt     = in_ch.last_in ? 2'd2 : 2'd0;
          pos_nxt       = in_ch.last_in ? rlad_pkg::POS_START : rlad_pkg::POS_FULL;
        end
      endcase
    end
  end

  // Output register: load when the slot is free, else hold.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    out_last_nxt  = out_last_r;
    if (slot_free) begin
      out_valid_nxt = fire_out;
      if (fire_out) begin
        out_pix_nxt  = PW'(filt);
        out_last_nxt = emit_last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= rlad_pkg::POS_START;
      emit_r      <= 1'b0;
      emit_last_r <= 1'b0;
      flush_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      emit_r      <= emit_nxt;
      emit_last_r <= emit_last_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    shift_r    <= shift_nxt;
    mode_r     <= mode_nxt;
    out_pix_r  <= out_pix_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = out_pix_r;
  assign out_ch.last_out  = out_last_r;

  // A pending flush always sits behind a pending result.
  `RLAD_ASSERT(a_flush_has_emit, clk, rst_n, (flush_r != 2'd0) |-> emit_r, "flush without result")
  // The final result of a line has no flush behind it.
  `RLAD_ASSERT(a_last_ends_flush, clk, rst_n, emit_last_r |-> (flush_r == 2'd0), "last with flush")
  // The last pixel of a full window schedules two flush copies.
  `RLAD_ASSERT(a_full_last_flush, clk, rst_n, last_full_in |=> (flush_r == 2'd2), "flush count")
  // Reset empties the output register.
  `RLAD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

// ----- bench/tb_raw_line_adaptive_denoise_core.sv -----
// Self-checking testbench for the raw line adaptive denoise core.
`timescale 1ns / 1ps
module tb_raw_line_adaptive_denoise_core;
  import rlad_pkg::*;

  // Mode code 3 has no name in the package; the block treats it as five-tap.
  localparam logic [MODE_W-1:0] MODE_5TAP_ALT = 2'd3;
  localparam int                CYCLE_LIMIT   = 200000;
  localparam int                DRAIN_CYCLES  = 8;
  localparam int                RANDOM_PIXELS = 96;
  localparam int                NUM_DIRECTED  = 24;

  // One filtered pixel as it should leave the block.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } filtered_beat_t;

  // One row of stimulus. Where typed is set, the filtered values of this
  // beat are known by inspection and replace the predicted ones.
  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [SHIFT_W-1:0] shift;
    logic [MODE_W-1:0]  mode;
    logic               last;
    logic               typed;
    logic [PIX_W-1:0]   want0;
    logic [PIX_W-1:0]   want1;
    logic [PIX_W-1:0]   want2;
  } stim_row_t;

  logic clk;
  logic rst_n;

  rlad_in_if  in_if ();
  rlad_out_if out_if ();

  raw_line_adaptive_denoise_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Line filter predictor: mirror of the block's window, shift delay,
  // line position and latched mode.
  // ---------------------------------------------------------------------
  logic [PIX_W-1:0]   line_window [5];
  logic [SHIFT_W-1:0] shift_pipe  [3];
  logic [1:0]         line_pos;
  logic [MODE_W-1:0]  line_mode;

  filtered_beat_t pending_pixels [$];
  int             mismatches;
  bit             calm;          // no idling on either side while set

  // Filter the center of the current window with the latched mode.
  function automatic logic [PIX_W-1:0] filter_center();
    int unsigned l2, l1, c, r1, r2, v;
    longint      d, h;
    l2 = line_window[0];
    l1 = line_window[1];
    c  = line_window[2];
    r1 = line_window[3];
    r2 = line_window[4];
    if (line_mode == MODE_3TAP) begin
      return PIX_W'((4 * l1 + 8 * c + 4 * r1 + 8) / 16);
    end
    if (line_mode >= MODE_5TAP) begin
      return PIX_W'((2 * l2 + 4 * l1 + 4 * c + 4 * r1 + 2 * r2 + 8) / 16);
    end
    // Clamped smoothing: limit the 1-2-1 step to half of 2^shift of the
    // center pixel's block; shifts above 16 never bind.
    v = (l1 + 2 * c + r1 + 2) / 4;
    d = longint'(v) - longint'(c);
    h = (longint'(1) << shift_pipe[0]) / 2;
    if (d > h) d = h;
    if (d < -h) d = -h;
    return PIX_W'(longint'(c) + d);
  endfunction

  task automatic shift_in(input logic [PIX_W-1:0] pix, input logic [SHIFT_W-1:0] sh);
    for (int k = 0; k < 4; k++) line_window[k] = line_window[k + 1];
    line_window[4] = pix;
    shift_pipe[0]  = shift_pipe[1];
    shift_pipe[1]  = shift_pipe[2];
    shift_pipe[2]  = sh;
  endtask

  task automatic queue_filtered(input logic last);
    filtered_beat_t beat;
    beat.pix  = filter_center();
    beat.last = last;
    pending_pixels.push_back(beat);
  endtask

  // Advance the predictor by one accepted pixel; n returns the number of
  // filtered pixels this beat releases (zero to three).
  task automatic predict_line_step(input stim_row_t row, output int n);
    logic [1:0] pos;
    int         flushes;
    pos = (line_pos >= POS_FULL) ? POS_FULL : line_pos;
    n   = 0;
    if (pos == POS_START) begin
      // First pixel of a line: latch the mode and fill for the left clamp.
      line_mode = row.mode;
      for (int k = 0; k < 5; k++) line_window[k] = row.pix;
      for (int k = 0; k < 3; k++) shift_pipe[k] = row.shift;
    end else begin
      shift_in(row.pix, row.shift);
    end
    if (pos == POS_FULL) begin
      queue_filtered(1'b0);
      n++;
    end
    if (!row.last) begin
      line_pos = (pos == POS_START) ? POS_ONE : POS_FULL;
    end else begin
      // Flush with copies of the edge pixel for the right clamp.
      flushes = (pos == POS_START) ? 1 : 2;
      for (int k = 0; k < flushes; k++) begin
        shift_in(row.pix, row.shift);
        queue_filtered(k == flushes - 1);
        n++;
      end
      line_pos = POS_START;
    end
  endtask

  // ---------------------------------------------------------------------
  // Pixel sender
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one pixel beat, hold it until accepted, then predict it. Called
  // at a rising edge; valid gets exactly one assignment per edge.
  task automatic send_pixel(input stim_row_t row);
    int               gap;
    int               n;
    int               base;
    logic [PIX_W-1:0] want [3];
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.pixel_in    <= row.pix;
    in_if.block_shift <= row.shift;
    in_if.noise_mode  <= row.mode;
    in_if.last_in     <= row.last;
    do @(posedge clk); while (!in_if.ready);
    predict_line_step(row, n);
    if (row.typed) begin
      want[0] = row.want0;
      want[1] = row.want1;
      want[2] = row.want2;
      base    = pending_pixels.size() - n;
      for (int k = 0; k < n; k++) pending_pixels[base + k].pix = want[k];
    end
  endtask

  // Hold the sender off until every filtered pixel has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Directed table: edge clamps, extremes of every field, every mode.
  // ---------------------------------------------------------------------
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // single-pixel lines return the pixel itself in any mode
    '{16'hFFFF, 5'd0,  MODE_CLAMP,    1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'h0000},
    '{16'h0000, 5'd31, MODE_5TAP_ALT, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000},
    // flat full-scale line: three identical results on the last beat
    '{16'hFFFF, 5'd16, MODE_5TAP,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'hFFFF, 5'd16, MODE_CLAMP,    1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'hFFFF, 5'd16, MODE_3TAP,     1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    // three-tap on a full-swing pattern
    '{16'hFFFF, 5'd16, MODE_3TAP,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'h0000, 5'd16, MODE_CLAMP,    1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'hFFFF, 5'd0,  MODE_5TAP,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'h0000, 5'd31, MODE_3TAP,     1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    // five-tap
    '{16'h0000, 5'd3,  MODE_5TAP,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'hFFFF, 5'd3,  MODE_CLAMP,    1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'h8000, 5'd3,  MODE_3TAP,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'hFFFF, 5'd3,  MODE_5TAP,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'h0001, 5'd3,  MODE_5TAP,     1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    // mode code 3 on a two-pixel line
    '{16'h1234, 5'd1,  MODE_5TAP_ALT, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'hABCD, 5'd2,  MODE_CLAMP,    1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    // clamped smoothing across zero, small, sixteen and oversized shifts
    '{16'h0000, 5'd0,  MODE_CLAMP,    1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'hFFFF, 5'd1,  MODE_3TAP,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'h0000, 5'd16, MODE_3TAP,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'hFFFF, 5'd31, MODE_3TAP,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'h0000, 5'd5,  MODE_3TAP,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'hFFFF, 5'd4,  MODE_3TAP,     1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    // gentle ramp where the limit of shift 2 binds
    '{16'h0100, 5'd2,  MODE_CLAMP,    1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{16'h0200, 5'd2,  MODE_CLAMP,    1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000}
  };

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    stim_row_t          row;
    int                 sent;
    int                 lines;
    int                 line_len;
    int                 r;
    logic [PIX_W-1:0]   level;
    logic [SHIFT_W-1:0] blk_shift;

    // Known values on every input from time zero.
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.pixel_in    = '0;
    in_if.block_shift = '0;
    in_if.noise_mode  = MODE_CLAMP;
    in_if.last_in     = 1'b0;
    out_if.ready      = 1'b0;
    calm              = 1'b0;
    mismatches        = 0;
    line_pos          = POS_START;
    line_mode         = MODE_CLAMP;
    for (int k = 0; k < 5; k++) line_window[k] = '0;
    for (int k = 0; k < 3; k++) shift_pipe[k] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_pixel(directed_rows[i]);
    drain_results();

    // Random lines: mostly short, some spanning several 32-pixel blocks.
    // The mode field is random on every beat to show that only the first
    // beat of a line counts.
    sent  = 0;
    lines = 0;
    while (sent < RANDOM_PIXELS) begin
      r = $urandom_range(0, 99);
      if (r < 70) line_len = $urandom_range(1, 6);
      else if (r < 95) line_len = $urandom_range(7, 20);
      else line_len = $urandom_range(33, 70);
      // Trim the final line so the run stays near its pixel budget.
      if (line_len > RANDOM_PIXELS - sent) line_len = RANDOM_PIXELS - sent;
      calm  = ($urandom_range(0, 3) == 0);
      level = PIX_W'($urandom);
      for (int k = 0; k < line_len; k++) begin
        if (k % 32 == 0) begin
          blk_shift = ($urandom_range(0, 9) == 0) ? SHIFT_W'($urandom_range(17, 31))
                                                 : SHIFT_W'($urandom_range(0, 16));
        end
        r = $urandom_range(0, 9);
        if (r < 5) level = level + PIX_W'($urandom_range(0, 64)) - PIX_W'(32);
        else if (r < 8) level = PIX_W'($urandom);
        else level = (r == 8) ? '1 : '0;
        row       = '0;
        row.pix   = level;
        row.shift = blk_shift;
        row.mode  = MODE_W'($urandom_range(0, 3));
        row.last  = (k == line_len - 1);
        send_pixel(row);
      end
      sent  += line_len;
      lines += 1;
      if (lines == 6) drain_results();
    end
    calm = 1'b0;

    // Stop sending, wait for the tail, then watch for strays.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result receiver: check each beat against the oldest expectation and
  // stall at random, short stalls mostly and a few long ones.
  // ---------------------------------------------------------------------
  int             stall_left;
  filtered_beat_t oldest;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected beat: pixel_out %h last_out %b", out_if.pixel_out,
                 out_if.last_out);
          mismatches++;
        end else begin
          oldest = pending_pixels.pop_front();
          if (out_if.pixel_out !== oldest.pix) begin
            $error("pixel_out: expected %h, actual %h", oldest.pix, out_if.pixel_out);
            mismatches++;
          end
          if (out_if.last_out !== oldest.last) begin
            $error("last_out: expected %b, actual %b", oldest.last, out_if.last_out);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!calm) begin
          case ($urandom_range(0, 99)) inside
            [0:19]:  stall_left = $urandom_range(1, 3);
            [20:22]: stall_left = $urandom_range(10, 40);
            default: stall_left = 0;
          endcase
        end
      end
    end
  end

  // Watchdog: abort a hung run.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
